// ----- rtl/psev_pkg.sv -----
// shared constants and token codes for the postfix stack evaluator
package psev_pkg;

   // field widths
   localparam int OP_W = 4;
   localparam int VALUE_W = 16;
   localparam int STATUS_W = 2;

   // default operand stack depth
   localparam int DEFAULT_STACK_DEPTH = 256;

   // saturation limit for add and multiply
   localparam logic [VALUE_W-1:0] VALUE_MAX = 16'hffff;

   // token codes
   localparam logic [OP_W-1:0] OP_PUSH = 4'd0;
   localparam logic [OP_W-1:0] OP_AND  = 4'd1;
   localparam logic [OP_W-1:0] OP_OR   = 4'd2;
   localparam logic [OP_W-1:0] OP_XOR  = 4'd3;
   localparam logic [OP_W-1:0] OP_MUL  = 4'd4;
   localparam logic [OP_W-1:0] OP_DIV  = 4'd5;
   localparam logic [OP_W-1:0] OP_ADD  = 4'd6;
   localparam logic [OP_W-1:0] OP_SUB  = 4'd7;
   localparam logic [OP_W-1:0] OP_EQ   = 4'd8;
   localparam logic [OP_W-1:0] OP_LT   = 4'd9;
   localparam logic [OP_W-1:0] OP_GT   = 4'd10;
   localparam logic [OP_W-1:0] OP_NE   = 4'd11;
   localparam logic [OP_W-1:0] OP_MOD  = 4'd12;
   localparam logic [OP_W-1:0] OP_LE   = 4'd13;
   localparam logic [OP_W-1:0] OP_GE   = 4'd14;
   localparam logic [OP_W-1:0] OP_END  = 4'd15;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DEPTH = 2'd1;
   localparam logic [STATUS_W-1:0] ST_UNDER = 2'd2;
   localparam logic [STATUS_W-1:0] ST_OVER  = 2'd3;

endpackage

// ----- rtl/postfix_stack_evaluator.sv -----
// postfix expression evaluator with a memory-based operand stack
//
// Takes one decoded token per item and keeps the operand stack in a
// single synchronous memory (one write port, two read ports, registered
// read data). A push, or a token that underflows or overflows, finishes
// at accept; end reads the bottom entry, then waits for the result slot.
// A binary operator steps through accept, stack read, and compute and
// write back. Divide and modulo with a nonzero divisor add the S_DIV
// steps of the one-bit-per-cycle restoring divider. Only end
// gives a result item; the result register lets the next token be taken
// while that item waits. No clearing pass follows reset.
module postfix_stack_evaluator
   import psev_pkg::*;
#(
   parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // item in
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // op [3:0], value [19:4], zero [23:20]
   // item out
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // result [15:0], status [17:16], zero [23:18]
);

   localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int DIV_CNT_W = $clog2(VALUE_W);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_DIV,
      S_CALC,
      S_END
   } state_type;

   state_type               state_ff;
   logic [CNT_W-1:0]        count_ff;
   logic [STATUS_W-1:0]     error_ff;
   logic [OP_W-1:0]         op_ff;
   logic [VALUE_W-1:0]      lhs_ff;
   logic [VALUE_W-1:0]      rhs_ff;
   logic [VALUE_W-1:0]      quo_ff;
   logic [VALUE_W-1:0]      rem_ff;
   logic [DIV_CNT_W-1:0]    div_cnt_ff;
   logic                    rsp_valid_ff;
   logic [VALUE_W-1:0]      rsp_result_ff;
   logic [STATUS_W-1:0]     rsp_status_ff;

   // stack memory and its registered read data
   logic [VALUE_W-1:0]      stack_mem [STACK_DEPTH];
   logic [VALUE_W-1:0]      rd_a_ff;
   logic [VALUE_W-1:0]      rd_b_ff;

   logic                    accept;
   logic [OP_W-1:0]         req_op;
   logic [VALUE_W-1:0]      req_value;
   logic [CNT_W-1:0]        count_m1;
   logic [CNT_W-1:0]        count_m2;
   logic                    stack_full;
   logic                    stack_short;
   logic                    mem_we;
   logic [ADDR_W-1:0]       mem_waddr;
   logic [VALUE_W-1:0]      mem_wdata;
   logic                    rd_en;
   logic [ADDR_W-1:0]       rd_addr_a;
   logic [ADDR_W-1:0]       rd_addr_b;
   logic [2*VALUE_W-1:0]    product;
   logic [VALUE_W:0]        sum;
   logic [VALUE_W-1:0]      alu_result;
   logic [VALUE_W:0]        div_shift;
   logic [VALUE_W:0]        div_trial;
   logic                    rsp_free;
   logic [STATUS_W-1:0]     end_status;
   logic [VALUE_W-1:0]      end_result;

   // input unpacking and handshake
   assign req_op = req_tdata[OP_W-1:0];
   assign req_value = req_tdata[OP_W+VALUE_W-1:OP_W];
   assign req_tready = !reset && (state_ff == S_IDLE);
   assign accept = req_tvalid && req_tready;

   // output packing
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {6'd0, rsp_status_ff, rsp_result_ff};
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // stack depth checks
   assign count_m1 = count_ff - CNT_W'(1);
   assign count_m2 = count_ff - CNT_W'(2);
   assign stack_full = (count_ff >= CNT_W'(STACK_DEPTH));
   assign stack_short = (count_ff < CNT_W'(2));

   // arithmetic on the two popped operands
   assign product = {{VALUE_W{1'b0}}, lhs_ff} * {{VALUE_W{1'b0}}, rhs_ff};
   assign sum = {1'b0, lhs_ff} + {1'b0, rhs_ff};

   always_comb begin
      unique case (op_ff)
         OP_AND: alu_result = lhs_ff & rhs_ff;
         OP_OR:  alu_result = lhs_ff | rhs_ff;
         OP_XOR: alu_result = lhs_ff ^ rhs_ff;
         OP_MUL: alu_result = (product[2*VALUE_W-1:VALUE_W] != '0) ? VALUE_MAX
                                                                  : product[VALUE_W-1:0];
         OP_DIV: alu_result = (rhs_ff != '0) ? quo_ff : '0;
         OP_ADD: alu_result = sum[VALUE_W] ? VALUE_MAX : sum[VALUE_W-1:0];
         OP_SUB: alu_result = (lhs_ff >= rhs_ff) ? (lhs_ff - rhs_ff) : '0;
         OP_EQ:  alu_result = VALUE_W'(lhs_ff == rhs_ff);
         OP_LT:  alu_result = VALUE_W'(lhs_ff < rhs_ff);
         OP_GT:  alu_result = VALUE_W'(lhs_ff > rhs_ff);
         OP_NE:  alu_result = VALUE_W'(lhs_ff != rhs_ff);
         OP_MOD: alu_result = (rhs_ff != '0) ? rem_ff : '0;
         OP_LE:  alu_result = VALUE_W'(lhs_ff <= rhs_ff);
         default: alu_result = VALUE_W'(lhs_ff >= rhs_ff);
      endcase
   end

   // one restoring divide step
   assign div_shift = {rem_ff, quo_ff[VALUE_W-1]};
   assign div_trial = div_shift - {1'b0, rhs_ff};

   // end token outcome from the bottom entry
   always_comb begin
      end_result = '0;
      if (error_ff != ST_OK) begin
         end_status = error_ff;
      end else if (count_ff != CNT_W'(1)) begin
         end_status = ST_DEPTH;
      end else begin
         end_status = ST_OK;
         end_result = rd_a_ff;
      end
   end

   // memory port control
   always_comb begin
      mem_we = 1'b0;
      mem_waddr = count_ff[ADDR_W-1:0];
      mem_wdata = req_value;
      rd_en = 1'b0;
      rd_addr_a = count_m2[ADDR_W-1:0];
      rd_addr_b = count_m1[ADDR_W-1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_op == OP_PUSH) begin
                  mem_we = !stack_full;
               end else if (req_op == OP_END) begin
                  rd_en = 1'b1;
                  rd_addr_a = '0;
               end else begin
                  rd_en = !stack_short;
               end
            end
         end
         S_CALC: begin
            mem_we = 1'b1;
            mem_waddr = count_m2[ADDR_W-1:0];
            mem_wdata = alu_result;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // operand stack storage
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_a_ff <= stack_mem[rd_addr_a];
         rd_b_ff <= stack_mem[rd_addr_b];
      end
   end

   // token sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         error_ff <= ST_OK;
         rsp_valid_ff <= 1'b0;
         div_cnt_ff <= '0;
      end else begin
         // result slot drains unless an end token reloads it this cycle
         if (rsp_valid_ff && rsp_tready && state_ff != S_END) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  op_ff <= req_op;
                  if (req_op == OP_PUSH) begin
                     if (stack_full) begin
                        if (error_ff == ST_OK) begin
                           error_ff <= ST_OVER;
                        end
                     end else begin
                        count_ff <= count_ff + CNT_W'(1);
                     end
                  end else if (req_op == OP_END) begin
                     state_ff <= S_END;
                  end else if (stack_short) begin
                     if (error_ff == ST_OK) begin
                        error_ff <= ST_UNDER;
                     end
                  end else begin
                     state_ff <= S_READ;
                  end
               end
            end
            S_READ: begin
               lhs_ff <= rd_a_ff;
               rhs_ff <= rd_b_ff;
               quo_ff <= rd_a_ff;
               rem_ff <= '0;
               div_cnt_ff <= DIV_CNT_W'(VALUE_W - 1);
               if ((op_ff == OP_DIV || op_ff == OP_MOD) && rd_b_ff != '0) begin
                  state_ff <= S_DIV;
               end else begin
                  state_ff <= S_CALC;
               end
            end
            S_DIV: begin
               if (div_trial[VALUE_W]) begin
                  rem_ff <= div_shift[VALUE_W-1:0];
                  quo_ff <= {quo_ff[VALUE_W-2:0], 1'b0};
               end else begin
                  rem_ff <= div_trial[VALUE_W-1:0];
                  quo_ff <= {quo_ff[VALUE_W-2:0], 1'b1};
               end
               div_cnt_ff <= div_cnt_ff - DIV_CNT_W'(1);
               if (div_cnt_ff == '0) begin
                  state_ff <= S_CALC;
               end
            end
            S_CALC: begin
               count_ff <= count_m1;
               state_ff <= S_IDLE;
            end
            S_END: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_result_ff <= end_result;
                  rsp_status_ff <= end_status;
                  count_ff <= '0;
                  error_ff <= ST_OK;
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // depth never passes the stack size
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count above depth");

   // a write back pops exactly one entry
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CALC |=> count_ff == $past(count_m1))
      else $error("binary op did not pop one entry");

   // a new result item only comes from an end token
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_END))
      else $error("result item without end token");

   // an error result carries a zero value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ST_OK |-> rsp_result_ff == '0)
      else $error("nonzero result with error status");

   // the divider runs only on a nonzero divisor
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> rhs_ff != '0 && (op_ff == OP_DIV || op_ff == OP_MOD))
      else $error("divider started without a valid divide");

endmodule

// ----- dv/postfix_stack_evaluator_tb.sv -----
// testbench for the postfix stack evaluator: token stream in, expression results checked
module postfix_stack_evaluator_tb
   import psev_pkg::*;
();

   localparam int STACK_DEPTH = DEFAULT_STACK_DEPTH;
   localparam int HALF_PERIOD = 6;
   localparam int CYCLE_LIMIT = 300000;
   localparam int RANDOM_TOKENS = 1600;
   localparam int LONG_HOLD = 400;
   localparam int SETTLE_CYCLES = 40;

   typedef struct {
      logic [OP_W-1:0]    op;
      logic [VALUE_W-1:0] value;
      bit                 drain;
   } token_type;

   typedef struct packed {
      logic [VALUE_W-1:0]  result;
      logic [STATUS_W-1:0] status;
   } outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // op [3:0], value [19:4], zero [23:20]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // result [15:0], status [17:16], zero [23:18]

   token_type   pending_tokens[$];
   outcome_type expected_results[$];
   int          tokens_queued = 0;
   bit          drain_next = 1'b0;

   // predictor state
   logic [VALUE_W-1:0]  operand_mem [STACK_DEPTH];
   int                  held = 0;
   logic [STATUS_W-1:0] first_error = ST_OK;

   int          failures = 0;
   int          results_seen = 0;
   int unsigned cycles = 0;
   bit          req_taken = 1'b0;

   postfix_stack_evaluator #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // binary operator on lhs and rhs, with saturation and zero-divisor rules
   function automatic logic [VALUE_W-1:0] combine_operands(input logic [OP_W-1:0] op,
                                                           input logic [VALUE_W-1:0] lhs,
                                                           input logic [VALUE_W-1:0] rhs);
      logic [31:0] wide;
      case (op)
         OP_AND: return lhs & rhs;
         OP_OR:  return lhs | rhs;
         OP_XOR: return lhs ^ rhs;
         OP_MUL: begin
            wide = lhs * rhs;
            return (wide > VALUE_MAX) ? VALUE_MAX : wide[VALUE_W-1:0];
         end
         OP_DIV: return (rhs != 0) ? lhs / rhs : '0;
         OP_ADD: begin
            wide = lhs + rhs;
            return (wide > VALUE_MAX) ? VALUE_MAX : wide[VALUE_W-1:0];
         end
         OP_SUB: return (lhs >= rhs) ? lhs - rhs : '0;
         OP_EQ:  return {15'd0, lhs == rhs};
         OP_LT:  return {15'd0, lhs < rhs};
         OP_GT:  return {15'd0, lhs > rhs};
         OP_NE:  return {15'd0, lhs != rhs};
         OP_MOD: return (rhs != 0) ? lhs % rhs : '0;
         OP_LE:  return {15'd0, lhs <= rhs};
         default: return {15'd0, lhs >= rhs};
      endcase
   endfunction

   // advance the predicted stack by one accepted token
   task automatic eval_token(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value);
      outcome_type done;
      logic [VALUE_W-1:0] lhs;
      logic [VALUE_W-1:0] rhs;
      if (op == OP_PUSH) begin
         if (held >= STACK_DEPTH) begin
            if (first_error == ST_OK) first_error = ST_OVER;
         end else begin
            operand_mem[held] = value;
            held++;
         end
      end else if (op == OP_END) begin
         done.result = '0;
         if (first_error != ST_OK) begin
            done.status = first_error;
         end else if (held != 1) begin
            done.status = ST_DEPTH;
         end else begin
            done.status = ST_OK;
            done.result = operand_mem[0];
         end
         expected_results.push_back(done);
         held = 0;
         first_error = ST_OK;
      end else if (held < 2) begin
         if (first_error == ST_OK) first_error = ST_UNDER;
      end else begin
         rhs = operand_mem[held-1];
         lhs = operand_mem[held-2];
         held--;
         operand_mem[held-1] = combine_operands(op, lhs, rhs);
      end
   endtask

   // stimulus helpers
   task automatic queue_token(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value);
      token_type tok;
      tok.op = op;
      tok.value = value;
      tok.drain = drain_next;
      drain_next = 1'b0;
      pending_tokens.push_back(tok);
      tokens_queued++;
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'h0001;
         2: return 16'hffff;
         3, 4: return 16'($urandom_range(0, 15));
         5: return 16'($urandom_range(0, 255));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [OP_W-1:0] pick_operator();
      return 4'($urandom_range(1, 14));
   endfunction

   task automatic queue_pair(input logic [VALUE_W-1:0] value, input logic [OP_W-1:0] op);
      queue_token(OP_PUSH, value);
      queue_token(op, 16'($urandom));
   endtask

   // well-formed expression with n_ops operators; extra pushes leave the depth wrong
   task automatic queue_expression(input int n_ops, input int extra);
      int held_now;
      int ops_left;
      int pushes_left;
      held_now = 0;
      ops_left = n_ops;
      pushes_left = n_ops + 1 + extra;
      while (ops_left > 0 || pushes_left > 0) begin
         if (pushes_left > 0 &&
             (held_now < 2 || ops_left == 0 || $urandom_range(0, 2) != 0)) begin
            queue_token(OP_PUSH, pick_value());
            held_now++;
            pushes_left--;
         end else begin
            queue_token(pick_operator(), 16'($urandom));
            held_now--;
            ops_left--;
         end
      end
      queue_token(OP_END, 16'($urandom));
   endtask

   task automatic queue_directed();
      // end with an empty stack, then an operator on an empty stack
      queue_token(OP_END, 16'hffff);
      queue_token(OP_ADD, 16'h0000);
      queue_token(OP_END, 16'h0000);
      // one chain through every operator: saturation, clamp, zero divisors
      queue_token(OP_PUSH, 16'hffff);
      queue_pair(16'hffff, OP_MUL);
      queue_pair(16'h0001, OP_ADD);
      queue_pair(16'h0000, OP_DIV);
      queue_pair(16'h0005, OP_SUB);
      queue_pair(16'h0000, OP_EQ);
      queue_pair(16'h0003, OP_OR);
      queue_pair(16'h0006, OP_AND);
      queue_pair(16'h0007, OP_XOR);
      queue_pair(16'h0000, OP_MOD);
      queue_pair(16'h0000, OP_LE);
      queue_pair(16'h0001, OP_GE);
      queue_pair(16'h0001, OP_NE);
      queue_pair(16'h0000, OP_LT);
      queue_pair(16'h0000, OP_GT);
      queue_token(OP_END, 16'h0000);
   endtask

   task automatic queue_random();
      bit full_done;
      bit over_done;
      int n;
      full_done = 1'b0;
      over_done = 1'b0;
      drain_next = 1'b1;
      while (tokens_queued < RANDOM_TOKENS) begin
         if (!full_done && tokens_queued > 300) begin
            // fill the stack exactly, reduce it to one value, read the bottom entry
            full_done = 1'b1;
            for (int i = 0; i < STACK_DEPTH; i++) queue_token(OP_PUSH, pick_value());
            for (int i = 1; i < STACK_DEPTH; i++) queue_token(pick_operator(), 16'($urandom));
            queue_token(OP_END, 16'($urandom));
         end else if (!over_done && tokens_queued > 900) begin
            // pushes past a full stack are dropped and flagged
            over_done = 1'b1;
            for (int i = 0; i < STACK_DEPTH + 2; i++) queue_token(OP_PUSH, pick_value());
            queue_token(OP_ADD, 16'($urandom));
            queue_token(OP_END, 16'($urandom));
         end else begin
            if ($urandom_range(0, 29) == 0) drain_next = 1'b1;
            case ($urandom_range(0, 9))
               7: queue_expression($urandom_range(0, 5), $urandom_range(1, 3));
               8: begin
                  // operator short of operands, then an otherwise valid expression
                  n = $urandom_range(0, 1);
                  for (int i = 0; i < n; i++) queue_token(OP_PUSH, pick_value());
                  queue_token(pick_operator(), 16'($urandom));
                  queue_expression($urandom_range(0, 4), 0);
               end
               9: begin
                  // arbitrary tokens, usually closed by an end
                  n = $urandom_range(1, 8);
                  for (int i = 0; i < n; i++) queue_token(4'($urandom_range(0, 14)), pick_value());
                  if ($urandom_range(0, 3) != 0) queue_token(OP_END, 16'($urandom));
               end
               default: begin
                  n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 5);
                  queue_expression(n, 0);
               end
            endcase
         end
      end
   endtask

   // sender: bursts of items with gaps, waits for a drain mark before some sequences
   int        burst_left = 1;
   int        gap_left = 0;
   token_type next_tok;

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_tokens.size() == 0 ||
                      (pending_tokens[0].drain && expected_results.size() != 0)) begin
            req_tvalid <= 1'b0;
         end else begin
            next_tok = pending_tokens.pop_front();
            req_tdata <= {4'b0, next_tok.value, next_tok.op};
            req_tvalid <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               if ($urandom_range(0, 3) == 0) begin
                  gap_left = 0;
                  burst_left = $urandom_range(40, 150);
               end else begin
                  gap_left = $urandom_range(1, 8);
                  burst_left = $urandom_range(1, 12);
               end
            end
         end
      end
   end

   // receiver: changing stall patterns plus occasional long hold-offs
   int pattern = 0;
   int pattern_left = 0;
   int hold_left = 0;
   int next_hold_at = 25;

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (hold_left == 0 && results_seen >= next_hold_at) begin
            hold_left = LONG_HOLD;
            next_hold_at += 120;
         end
         if (pattern_left == 0) begin
            pattern = $urandom_range(0, 3);
            pattern_left = $urandom_range(16, 128);
         end else begin
            pattern_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (pattern)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 3) != 0);
               2: rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= pattern_left[1];
            endcase
         end
      end
   end

   // monitor: predict on accepted tokens, compare accepted results
   outcome_type want;

   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) eval_token(req_tdata[3:0], req_tdata[19:4]);
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               $error("unexpected result item: result %0d status %0d",
                      rsp_tdata[15:0], rsp_tdata[17:16]);
               failures++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata[15:0] !== want.result) begin
                  $error("result: expected %0d, got %0d", want.result, rsp_tdata[15:0]);
                  failures++;
               end
               if (rsp_tdata[17:16] !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tdata[17:16]);
                  failures++;
               end
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      queue_directed();
      queue_random();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (pending_tokens.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
